>>> sv/tlrq_pkg.sv
// Shared types and codes for the three-level ready queue with aging.
// No dependencies.
package tlrq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_PICK    = 2'd1,
    OP_AGE     = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_L1_FLOOR  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_L2_FLOOR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AGE_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AGE_STEP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_CEIL = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] burst_estimate;
    logic [31:0] now_ticks;
  } in_t;

  typedef struct packed {
    logic [7:0] picked_id;
    logic [1:0] picked_level;
    logic [1:0] status;
  } out_t;

endpackage

>>> sv/three_level_ready_queue_with_aging_core.sv
// Three-level ready queue with aging: top level, slot table and sequencer.
// Depends on tlrq_pkg.
//
// Usage: one request is taken on the in channel (op, task fields, now_ticks),
// and exactly one result is returned on the out channel (picked_id,
// picked_level, status). Configuration registers are written through the
// cfg channel, which is always ready; write only while the block is idle.
// Operation: the table is walked by a single comparator, one slot per cycle.
//   enqueue : stops at the lowest free slot, or walks the whole table if full
//   pick    : walks the whole table
//   aging   : the walk stops at each valid slot, which runs a
//             32-step restoring divider, then one multiply and a write-back
//   op 3    : all-zero result
// One request is in flight at a time; in_ready_o is low from acceptance
// until its result has been transferred.
// Reset empties the table, clears the order counter and loads the register
// defaults. A stalled receiver holds the result in the output register and
// keeps the block from taking the next request.
module three_level_ready_queue_with_aging_core #(
  parameter int unsigned TABLE_SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tlrq_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tlrq_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tlrq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import tlrq_pkg::*;

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);
  localparam logic [CntW-1:0] CntEnd = CntW'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_ENQ, S_PICK, S_AGE_SCAN, S_AGE_DIV, S_AGE_MUL, S_AGE_WB
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  out_t   out_q;
  in_t    req_q;

  logic [7:0]  l1_floor_q, l2_floor_q, age_step_q, ceil_q;
  logic [15:0] limit_q;

  logic [TABLE_SLOTS-1:0] valid_q;
  logic [CntW-1:0]        cnt_q;
  logic [31:0]            order_cnt_q;

  logic [7:0]  task_q  [TABLE_SLOTS];
  logic [7:0]  prio_q  [TABLE_SLOTS];
  logic [15:0] burst_q [TABLE_SLOTS];
  logic [15:0] accum_q [TABLE_SLOTS];
  logic [31:0] start_q [TABLE_SLOTS];
  logic [31:0] order_q [TABLE_SLOTS];

  logic        found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [1:0]  best_lvl_q;
  logic [15:0] best_burst_q;
  logic [7:0]  best_prio_q;
  logic [31:0] best_order_q;
  logic [7:0]  best_task_q;

  logic [31:0] dvd_q;
  logic [15:0] rem_q;
  logic [4:0]  bit_q;
  logic [39:0] prod_q;
  logic        steps_nz_q;

  function automatic logic [1:0] level_of(logic [7:0] p, logic [7:0] f1, logic [7:0] f2);
    logic [1:0] l;
    if (p >= f1)      l = 2'd1;
    else if (p >= f2) l = 2'd2;
    else              l = 2'd3;
    return l;
  endfunction

  logic [IdxW-1:0] idx;
  logic            at_end;
  logic [7:0]      cur_prio;
  logic [1:0]      cur_lvl;
  logic            first;
  logic            take;
  logic [31:0]     age_cur, age_best;
  logic [15:0]     lim;
  logic [16:0]     shifted;
  logic            qbit;
  logic [16:0]     rem_next;
  logic [32:0]     sum33;
  logic [31:0]     sum_sat;
  logic [40:0]     raised;
  logic [7:0]      new_prio;
  logic            lvl_change;

  assign idx      = cnt_q[IdxW-1:0];
  assign at_end   = (cnt_q == CntEnd);
  assign cur_prio = prio_q[idx];
  assign cur_lvl  = level_of(cur_prio, l1_floor_q, l2_floor_q);
  assign age_cur  = order_cnt_q - order_q[idx];
  assign age_best = order_cnt_q - best_order_q;
  assign lim      = (limit_q == 16'd0) ? 16'd1 : limit_q;
  assign shifted  = {rem_q, dvd_q[31]};
  assign qbit     = (shifted >= {1'b0, lim});
  assign rem_next = qbit ? (shifted - {1'b0, lim}) : shifted;
  assign sum33    = {17'd0, accum_q[idx]} + {1'b0, req_q.now_ticks - start_q[idx]};
  assign sum_sat  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
  assign raised   = {1'b0, prod_q} + {33'd0, cur_prio};

  always_comb begin
    if (cur_lvl == 2'd1 && burst_q[idx] != best_burst_q) begin
      first = burst_q[idx] < best_burst_q;
    end else if (cur_lvl == 2'd2 && cur_prio != best_prio_q) begin
      first = cur_prio > best_prio_q;
    end else begin
      first = age_cur > age_best;
    end
    take = valid_q[idx] &&
           (!found_q || cur_lvl < best_lvl_q || (cur_lvl == best_lvl_q && first));
    if (!steps_nz_q)                  new_prio = cur_prio;
    else if (raised >= {33'd0, ceil_q}) new_prio = ceil_q;
    else                              new_prio = raised[7:0];
    lvl_change = level_of(new_prio, l1_floor_q, l2_floor_q) != cur_lvl;
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // control: state, valid bits, counters, config, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      order_cnt_q <= '0;
      found_q     <= 1'b0;
      bit_q       <= '0;
      l1_floor_q  <= 8'd100;
      l2_floor_q  <= 8'd50;
      limit_q     <= 16'd1500;
      age_step_q  <= 8'd10;
      ceil_q      <= 8'd149;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_L1_FLOOR:  l1_floor_q <= cfg_data_i[7:0];
          CFG_L2_FLOOR:  l2_floor_q <= cfg_data_i[7:0];
          CFG_AGE_LIMIT: limit_q    <= cfg_data_i;
          CFG_AGE_STEP:  age_step_q <= cfg_data_i[7:0];
          CFG_PRIO_CEIL: ceil_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cnt_q   <= '0;
            found_q <= 1'b0;
            unique case (op_e'(in_data_i.op))
              OP_ENQUEUE: state_q <= S_ENQ;
              OP_PICK:    state_q <= S_PICK;
              OP_AGE:     state_q <= S_AGE_SCAN;
              default: begin
                out_valid_q <= 1'b1;
                out_q       <= '0;
              end
            endcase
          end
        end
        S_ENQ: begin
          if (at_end) begin
            out_valid_q <= 1'b1;
            out_q       <= '{picked_id: 8'd0, picked_level: 2'd0, status: ST_FULL};
            state_q     <= S_IDLE;
          end else if (!valid_q[idx]) begin
            valid_q[idx] <= 1'b1;
            order_cnt_q  <= order_cnt_q + 32'd1;
            out_valid_q  <= 1'b1;
            out_q        <= '{picked_id: 8'd0, picked_level: 2'd0, status: ST_OK};
            state_q      <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_PICK: begin
          if (at_end) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (found_q) begin
              valid_q[best_idx_q] <= 1'b0;
              out_q <= '{picked_id: best_task_q, picked_level: best_lvl_q, status: ST_OK};
            end else begin
              out_q <= '{picked_id: 8'd0, picked_level: 2'd0, status: ST_EMPTY};
            end
          end else begin
            if (take) found_q <= 1'b1;
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_AGE_SCAN: begin
          if (at_end) begin
            out_valid_q <= 1'b1;
            out_q       <= '{picked_id: 8'd0, picked_level: 2'd0, status: ST_OK};
            state_q     <= S_IDLE;
          end else if (valid_q[idx]) begin
            bit_q   <= '0;
            state_q <= S_AGE_DIV;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_AGE_DIV: begin
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) state_q <= S_AGE_MUL;
        end
        S_AGE_MUL: state_q <= S_AGE_WB;
        S_AGE_WB: begin
          if (lvl_change) order_cnt_q <= order_cnt_q + 32'd1;
          cnt_q   <= cnt_q + CntW'(1);
          state_q <= S_AGE_SCAN;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath: slot table and scan/divider registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && in_ready_o) req_q <= in_data_i;
    case (state_q)
      S_ENQ: begin
        if (!at_end && !valid_q[idx]) begin
          task_q[idx]  <= req_q.task_id;
          prio_q[idx]  <= req_q.task_priority;
          burst_q[idx] <= req_q.burst_estimate;
          accum_q[idx] <= 16'd0;
          start_q[idx] <= req_q.now_ticks;
          order_q[idx] <= order_cnt_q;
        end
      end
      S_PICK: begin
        if (!at_end && take) begin
          best_idx_q   <= idx;
          best_lvl_q   <= cur_lvl;
          best_burst_q <= burst_q[idx];
          best_prio_q  <= cur_prio;
          best_order_q <= order_q[idx];
          best_task_q  <= task_q[idx];
        end
      end
      S_AGE_SCAN: begin
        dvd_q <= sum_sat;
        rem_q <= 16'd0;
      end
      S_AGE_DIV: begin
        dvd_q <= {dvd_q[30:0], qbit};
        rem_q <= rem_next[15:0];
      end
      S_AGE_MUL: begin
        prod_q     <= {8'd0, dvd_q} * {32'd0, age_step_q};
        steps_nz_q <= (dvd_q != 32'd0);
      end
      S_AGE_WB: begin
        accum_q[idx] <= rem_q;
        start_q[idx] <= req_q.now_ticks;
        prio_q[idx]  <= new_prio;
        if (lvl_change) order_q[idx] <= order_cnt_q;
      end
      default: ;
    endcase
  end

  ast_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input taken while busy");

  ast_empty_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_q.status == ST_EMPTY) |-> (valid_q == '0))
    else $error("empty pick with valid slots");

  ast_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_q.status == ST_FULL) |-> (&valid_q))
    else $error("full status with free slot");

  ast_rem_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE_MUL) |-> (rem_q < lim))
    else $error("divider remainder out of range");

endmodule

>>> test/tb_three_level_ready_queue_with_aging_core.sv
// Self-checking testbench for three_level_ready_queue_with_aging_core.
// Directed table, then random phases under changing register settings, checked against a
// local scheduler model. Depends on tlrq_pkg and the core.
module tb_three_level_ready_queue_with_aging_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tlrq_pkg::*;

  localparam int unsigned Slots = 32;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  three_level_ready_queue_with_aging_core #(.TABLE_SLOTS(Slots)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // scheduler model state
  logic [7:0]  l1_floor, l2_floor, age_step, prio_ceil;
  logic [15:0] age_limit;
  bit          sv_valid [Slots];
  logic [7:0]  sv_task [Slots];
  logic [7:0]  sv_prio [Slots];
  logic [15:0] sv_burst [Slots];
  logic [31:0] sv_accum [Slots];
  logic [31:0] sv_start [Slots];
  logic [31:0] sv_order [Slots];
  logic [31:0] stamp_ctr;

  out_t        pending_picks [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen = 0;
  int unsigned empty_seen = 0;
  int unsigned idle_cycles = 0;
  bit          idle_en = 1'b1;
  logic [31:0] cur_now = '0;

  typedef struct {
    in_t  d;
    bit   typed;
    out_t e;
  } row_t;
  row_t rows [$];

  function automatic logic [1:0] level_of(logic [7:0] p);
    if (p >= l1_floor) return 2'd1;
    if (p >= l2_floor) return 2'd2;
    return 2'd3;
  endfunction

  function automatic bit ahead_of(int a, int b, logic [1:0] lvl);
    logic [31:0] age_a, age_b;
    age_a = stamp_ctr - sv_order[a];
    age_b = stamp_ctr - sv_order[b];
    if (lvl == 2'd1 && sv_burst[a] != sv_burst[b]) return sv_burst[a] < sv_burst[b];
    if (lvl == 2'd2 && sv_prio[a] != sv_prio[b]) return sv_prio[a] > sv_prio[b];
    return age_a > age_b;
  endfunction

  function automatic out_t schedule_step(in_t d);
    out_t r;
    int best;
    logic [1:0] best_lvl, lvl, old_lvl;
    logic [31:0] lim, elapsed, sum32, steps;
    logic [63:0] sum, p;
    r = '0;
    best = -1;
    best_lvl = 2'd3;
    case (op_e'(d.op))
      OP_ENQUEUE: begin
        for (int i = 0; i < Slots; i++) begin
          if (!sv_valid[i] && best < 0) best = i;
        end
        if (best < 0) begin
          r.status = ST_FULL;
        end else begin
          sv_valid[best] = 1'b1;
          sv_task[best] = d.task_id;
          sv_prio[best] = d.task_priority;
          sv_burst[best] = d.burst_estimate;
          sv_accum[best] = '0;
          sv_start[best] = d.now_ticks;
          sv_order[best] = stamp_ctr;
          stamp_ctr++;
        end
      end
      OP_PICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (sv_valid[i]) begin
            lvl = level_of(sv_prio[i]);
            if (best < 0 || lvl < best_lvl || (lvl == best_lvl && ahead_of(i, best, lvl))) begin
              best = i;
              best_lvl = lvl;
            end
          end
        end
        if (best < 0) begin
          r.status = ST_EMPTY;
        end else begin
          sv_valid[best] = 1'b0;
          r.picked_id = sv_task[best];
          r.picked_level = best_lvl;
        end
      end
      OP_AGE: begin
        lim = (age_limit == 0) ? 32'd1 : {16'd0, age_limit};
        for (int i = 0; i < Slots; i++) begin
          if (sv_valid[i]) begin
            old_lvl = level_of(sv_prio[i]);
            elapsed = d.now_ticks - sv_start[i];
            sum = {32'd0, sv_accum[i]} + {32'd0, elapsed};
            sum32 = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            sv_start[i] = d.now_ticks;
            steps = sum32 / lim;
            sv_accum[i] = sum32 % lim;
            if (steps > 0) begin
              p = {56'd0, sv_prio[i]} + {32'd0, steps} * {56'd0, age_step};
              sv_prio[i] = (p >= {56'd0, prio_ceil}) ? prio_ceil : p[7:0];
            end
            if (level_of(sv_prio[i]) != old_lvl) begin
              sv_order[i] = stamp_ctr;
              stamp_ctr++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [15:0] v);
    case (idx)
      CFG_L1_FLOOR:  l1_floor = v[7:0];
      CFG_L2_FLOOR:  l2_floor = v[7:0];
      CFG_AGE_LIMIT: age_limit = v;
      CFG_AGE_STEP:  age_step = v[7:0];
      CFG_PRIO_CEIL: prio_ceil = v[7:0];
      default: ;
    endcase
  endfunction

  function automatic in_t mk(op_e op, logic [7:0] id, logic [7:0] pr, logic [15:0] bu,
                             logic [31:0] now);
    in_t d;
    d.op = op;
    d.task_id = id;
    d.task_priority = pr;
    d.burst_estimate = bu;
    d.now_ticks = now;
    return d;
  endfunction

  // enq_pct biases the op mix; high values fill the table
  function automatic in_t rand_item(int unsigned enq_pct);
    in_t d;
    int unsigned r;
    r = $urandom_range(0, 99);
    d.task_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    d.task_priority = 8'($urandom);
    d.burst_estimate = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    if ($urandom_range(0, 19) == 0) cur_now = $urandom;
    else cur_now = cur_now + $urandom_range(0, 4000);
    d.now_ticks = cur_now;
    if (r < enq_pct) d.op = OP_ENQUEUE;
    else if (r < enq_pct + (100 - enq_pct) / 2) d.op = OP_PICK;
    else if (r < 96) d.op = OP_AGE;
    else d.op = OP_NONE;
    return d;
  endfunction

  task automatic send_item(in_t d, bit typed, out_t e);
    out_t pred;
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    pred = schedule_step(d);
    pending_picks.push_back(typed ? e : pred);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.status == ST_FULL) full_seen++;
      if (out_data_o.status == ST_EMPTY) empty_seen++;
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        e = pending_picks.pop_front();
        if (out_data_o.picked_id !== e.picked_id || out_data_o.picked_level !== e.picked_level
            || out_data_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp id %0d lvl %0d st %0d, got id %0d lvl %0d st %0d",
                     e.picked_id, e.picked_level, e.status, out_data_o.picked_id,
                     out_data_o.picked_level, out_data_o.status);
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    out_t z, emp, ok;
    int unsigned enq_pct;
    logic [15:0] v [5];
    z = '0;
    emp = '0;
    emp.status = ST_EMPTY;
    ok = '0;
    l1_floor = 8'd100;
    l2_floor = 8'd50;
    age_limit = 16'd1500;
    age_step = 8'd10;
    prio_ceil = 8'd149;
    stamp_ctr = '0;
    foreach (sv_valid[i]) sv_valid[i] = 1'b0;

    rows.push_back('{mk(OP_PICK, 8'd0, 8'd0, 16'd0, 32'd0), 1'b1, emp});
    rows.push_back('{mk(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1, z});
    rows.push_back('{mk(OP_AGE, 8'd0, 8'd0, 16'd0, 32'd5), 1'b1, z});
    rows.push_back('{mk(OP_ENQUEUE, 8'd0, 8'd0, 16'd0, 32'd0), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'd7, 8'd100, 16'd5, 32'd0), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'd8, 8'd100, 16'd5, 32'd0), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'd9, 8'd60, 16'd0, 32'd0), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'd10, 8'd60, 16'd9, 32'd0), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'd7, 8'd49, 16'd1, 32'd0), 1'b1, ok});
    rows.push_back('{mk(OP_ENQUEUE, 8'd12, 8'd50, 16'd1, 32'd0), 1'b1, ok});
    // elapsed wraps for the entry stamped at the top of the tick range
    rows.push_back('{mk(OP_AGE, 8'd0, 8'd0, 16'd0, 32'd3000), 0, z});
    rows.push_back('{mk(OP_AGE, 8'd0, 8'd0, 16'd0, 32'd3100), 0, z});
    for (int i = 0; i < 9; i++) rows.push_back('{mk(OP_PICK, 8'd0, 8'd0, 16'd0, 32'd0), 0, z});
    rows.push_back('{mk(OP_NONE, 8'd0, 8'd0, 16'd0, 32'd0), 1'b1, z});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].d, rows[i].typed, rows[i].e);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: v = '{16'd255, 16'd0, 16'd1, 16'd255, 16'd255};
        1: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        2: v = '{16'd100, 16'd50, 16'd65535, 16'd10, 16'd149};
        3: v = '{16'd255, 16'd255, 16'd1, 16'd1, 16'd254};
        default: v = '{16'($urandom), 16'($urandom), 16'($urandom_range(0, 6000)),
                       16'($urandom), 16'($urandom)};
      endcase
      if (ph == NumPhases - 1) idle_en = 1'b0;
      for (int r = 0; r < 5; r++) write_reg(CfgIdxW'(r), v[r]);
      enq_pct = (ph % 3 == 0) ? 85 : 40;
      for (int n = 0; n < PhaseItems; n++) send_item(rand_item(enq_pct), 1'b0, z);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("ran %0d directed and %0d random requests over %0d register settings",
             rows.size(), NumPhases * PhaseItems, NumPhases + 1);
    $display("%0d results checked, %0d full, %0d empty, %0d mismatches",
             results_seen, full_seen, empty_seen, mismatches);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
